// ----- rtl/core/fmsa_pkg.sv -----
// Shared types and constants for the filtered mean and deviation accumulator.
`timescale 1ns / 1ps
`default_nettype none
package fmsa_pkg;

  // Fixed field widths.
  localparam int MeasW  = 24;
  localparam int CntW   = 17;
  localparam int SumW   = 41;
  localparam int SqW    = 64;
  localparam int ProdW  = 105;
  localparam int NumW   = 82;
  localparam int DenW   = 35;
  localparam int StepW  = 7;
  localparam logic [22:0] StdMax = 23'h7FFFFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [2:0] CFG_TYPE_MATCH  = 3'd1;
  localparam logic [2:0] CFG_LOC_MATCH   = 3'd2;
  localparam logic [2:0] CFG_ID_MATCH    = 3'd3;
  localparam logic [2:0] CFG_WIN_START   = 3'd4;
  localparam logic [2:0] CFG_WIN_END     = 3'd5;

  // Filter modes.
  localparam logic [1:0] MODE_TYPE     = 2'd0;
  localparam logic [1:0] MODE_TYPE_LOC = 2'd1;
  localparam logic [1:0] MODE_WINDOW   = 2'd2;
  localparam logic [1:0] MODE_IDENT    = 2'd3;

  // Operations of the shared iterative datapath.
  typedef enum logic [2:0] {
    OP_MULA = 3'd0,
    OP_MULB = 3'd1,
    OP_MULC = 3'd2,
    OP_DIVM = 3'd3,
    OP_DIVV = 3'd4,
    OP_SQRT = 3'd5
  } op_e;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic run;
    op_e  op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic empty;
    logic done;
  } status_t;

  // Number of compute iterations of each operation.
  function automatic logic [StepW-1:0] op_steps(input op_e op);
    logic [StepW-1:0] n;
    case (op)
      OP_MULA, OP_MULB, OP_MULC: n = 7'd41;
      OP_DIVM, OP_DIVV:          n = 7'd82;
      OP_SQRT:                   n = 7'd32;
      default:                   n = 7'd41;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fmsa_ctrl.sv -----
// Controller state machine that sequences accumulation and the final statistics.
`timescale 1ns / 1ps
`default_nettype none
module fmsa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire fmsa_pkg::status_t status_i,
  output fmsa_pkg::cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ACC  = 9'b000000010,
    ST_MULA = 9'b000000100,
    ST_MULB = 9'b000001000,
    ST_MULC = 9'b000010000,
    ST_DIVM = 9'b000100000,
    ST_DIVV = 9'b001000000,
    ST_SQRT = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '{capture: 1'b0, accumulate: 1'b0, run: 1'b0,
                 op: fmsa_pkg::OP_MULA, emit: 1'b0};
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.empty) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd_o.run = 1'b1;
        cmd_o.op  = fmsa_pkg::OP_MULA;
        if (status_i.done) state_d = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.run = 1'b1;
        cmd_o.op  = fmsa_pkg::OP_MULB;
        if (status_i.done) state_d = ST_MULC;
      end
      ST_MULC: begin
        cmd_o.run = 1'b1;
        cmd_o.op  = fmsa_pkg::OP_MULC;
        if (status_i.done) state_d = ST_DIVM;
      end
      ST_DIVM: begin
        cmd_o.run = 1'b1;
        cmd_o.op  = fmsa_pkg::OP_DIVM;
        if (status_i.done) state_d = ST_DIVV;
      end
      ST_DIVV: begin
        cmd_o.run = 1'b1;
        cmd_o.op  = fmsa_pkg::OP_DIVV;
        if (status_i.done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.run = 1'b1;
        cmd_o.op  = fmsa_pkg::OP_SQRT;
        if (status_i.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Load the output register once the previous result has left.
        if (!ovalid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

endmodule
`default_nettype wire

// ----- rtl/core/fmsa_dp.sv -----
// Datapath: filter, accumulators, serial multiplier, divider and square root.
`timescale 1ns / 1ps
`default_nettype none
module fmsa_dp #(
  parameter int MaxRecords = 65536,
  parameter int MeasWidth  = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [3:0]  type_code_i,
  input  wire logic [3:0]  location_code_i,
  input  wire logic [15:0] sensor_ident_i,
  input  wire logic [31:0] sample_time_i,
  input  wire logic [23:0] measurement_i,
  input  wire logic        last_item_i,
  input  wire fmsa_pkg::cmd_t cmd_i,
  output fmsa_pkg::status_t   status_o,
  output logic [16:0]      match_total_o,
  output logic [23:0]      mean_value_o,
  output logic [22:0]      std_dev_o,
  output logic             empty_set_o
);

  localparam int Shift = fmsa_pkg::MeasW - MeasWidth;

  // Configuration registers.
  logic [1:0]  mode_q;
  logic [3:0]  type_q, loc_q;
  logic [15:0] id_q;
  logic [31:0] wstart_q, wend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= fmsa_pkg::MODE_TYPE;
      type_q   <= '0;
      loc_q    <= '0;
      id_q     <= '0;
      wstart_q <= '0;
      wend_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fmsa_pkg::CFG_FILTER_MODE: mode_q   <= cfg_data_i[1:0];
        fmsa_pkg::CFG_TYPE_MATCH:  type_q   <= cfg_data_i[3:0];
        fmsa_pkg::CFG_LOC_MATCH:   loc_q    <= cfg_data_i[3:0];
        fmsa_pkg::CFG_ID_MATCH:    id_q     <= cfg_data_i[15:0];
        fmsa_pkg::CFG_WIN_START:   wstart_q <= cfg_data_i;
        fmsa_pkg::CFG_WIN_END:     wend_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Filter decision for the incoming record.
  logic hit;
  logic tmatch, lmatch, tin;
  always_comb begin
    tmatch = (type_code_i == type_q);
    lmatch = (location_code_i == loc_q);
    tin    = (sample_time_i >= wstart_q) && (sample_time_i <= wend_q);
    case (mode_q)
      fmsa_pkg::MODE_TYPE:     hit = tmatch;
      fmsa_pkg::MODE_TYPE_LOC: hit = tmatch && lmatch;
      fmsa_pkg::MODE_WINDOW:   hit = tmatch && lmatch && tin;
      default:                 hit = (sensor_ident_i == id_q);
    endcase
  end

  // Captured record.
  logic signed [23:0] meas_q;
  logic               hit_q;
  logic               last_q;
  logic signed [23:0] meas_sx;
  assign meas_sx = $signed(measurement_i << Shift) >>> Shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      last_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q  <= hit;
      last_q <= last_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) meas_q <= meas_sx;
  end

  // Accumulators.
  logic [16:0]        cnt_q;
  logic signed [40:0] sum_q;
  logic [63:0]        sq_q;
  logic signed [47:0] square;
  assign square = meas_q * meas_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.accumulate && hit_q &&
                 (cnt_q < fmsa_pkg::CntW'(MaxRecords))) begin
      cnt_q <= cnt_q + 17'd1;
      sum_q <= sum_q + 41'(meas_q);
      sq_q  <= sq_q + 64'(unsigned'(square));
    end
  end

  logic        neg;
  logic [40:0] mag;
  assign neg = sum_q[40];
  assign mag = neg ? 41'(-sum_q) : 41'(sum_q);

  // Iterative units.
  logic [6:0]   step_q;
  logic [104:0] prod_q, mcand_q, prod_nx;
  logic [40:0]  mplier_q;
  logic [81:0]  num_q, quo_q, quo_nx;
  logic [33:0]  nsq_q;
  logic [34:0]  rem_q, rem_nx, den;
  logic [35:0]  r2;
  logic [63:0]  x_q;
  logic [31:0]  root_q, root_nx;
  logic [33:0]  sr_q, sr_nx, sr2, trial;
  logic [23:0]  mean_q;
  logic [22:0]  std_q;
  logic         done;

  assign done = (step_q == fmsa_pkg::op_steps(cmd_i.op));

  // One step of each unit.
  always_comb begin
    prod_nx = mplier_q[0] ? prod_q + mcand_q : prod_q;
    den = (cmd_i.op == fmsa_pkg::OP_DIVM) ? 35'({cnt_q, 1'b0}) : 35'(nsq_q);
    r2  = {rem_q, quo_q[81]};
    if (r2 >= {1'b0, den}) begin
      rem_nx = 35'(r2 - {1'b0, den});
      quo_nx = {quo_q[80:0], 1'b1};
    end else begin
      rem_nx = r2[34:0];
      quo_nx = {quo_q[80:0], 1'b0};
    end
    sr2   = {sr_q[31:0], x_q[63:62]};
    trial = {root_q, 2'b01};
    if (sr2 >= trial) begin
      sr_nx   = sr2 - trial;
      root_nx = {root_q[30:0], 1'b1};
    end else begin
      sr_nx   = sr2;
      root_nx = {root_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.run) begin
      step_q <= done ? '0 : step_q + 7'd1;
    end
  end

  // Operand loading, iteration and completion of each operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.run) begin
      if (step_q == '0) begin
        prod_q <= '0;
        rem_q  <= '0;
        sr_q   <= '0;
        root_q <= '0;
        case (cmd_i.op)
          fmsa_pkg::OP_MULA: begin
            mcand_q  <= 105'(sq_q);
            mplier_q <= 41'(cnt_q);
          end
          fmsa_pkg::OP_MULB: begin
            mcand_q  <= 105'(mag);
            mplier_q <= mag;
          end
          fmsa_pkg::OP_MULC: begin
            mcand_q  <= 105'(cnt_q);
            mplier_q <= 41'(cnt_q);
          end
          fmsa_pkg::OP_DIVM: quo_q <= 82'({mag, 1'b0}) + 82'(cnt_q);
          fmsa_pkg::OP_DIVV: quo_q <= num_q;
          fmsa_pkg::OP_SQRT: x_q <= (|quo_q[81:64]) ? '1 : quo_q[63:0];
          default: ;
        endcase
      end else begin
        case (cmd_i.op)
          fmsa_pkg::OP_MULA, fmsa_pkg::OP_MULB, fmsa_pkg::OP_MULC: begin
            prod_q   <= prod_nx;
            mcand_q  <= {mcand_q[103:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[40:1]};
          end
          fmsa_pkg::OP_DIVM, fmsa_pkg::OP_DIVV: begin
            rem_q <= rem_nx;
            quo_q <= quo_nx;
          end
          fmsa_pkg::OP_SQRT: begin
            sr_q   <= sr_nx;
            root_q <= root_nx;
            x_q    <= {x_q[61:0], 2'b00};
          end
          default: ;
        endcase
        if (done) begin
          case (cmd_i.op)
            fmsa_pkg::OP_MULA: num_q <= prod_nx[81:0];
            fmsa_pkg::OP_MULB: num_q <= num_q - prod_nx[81:0];
            fmsa_pkg::OP_MULC: nsq_q <= prod_nx[33:0];
            fmsa_pkg::OP_DIVM: mean_q <= neg ? 24'(24'd0 - quo_nx[23:0]) : quo_nx[23:0];
            fmsa_pkg::OP_SQRT: std_q <= (|root_nx[31:23]) ? fmsa_pkg::StdMax : root_nx[22:0];
            default: ;
          endcase
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      match_total_o <= cnt_q;
      empty_set_o   <= (cnt_q == '0);
      mean_value_o  <= (cnt_q == '0) ? '0 : mean_q;
      std_dev_o     <= (cnt_q == '0) ? '0 : std_q;
    end
  end

  // The set is empty only if the record being accumulated does not match either.
  assign status_o = '{last: last_q, empty: (cnt_q == '0) && !hit_q, done: done};

endmodule
`default_nettype wire

// ----- rtl/core/filtered_mean_stdev_accumulator.sv -----
// Top level of the filtered mean and standard deviation accumulator.
`timescale 1ns / 1ps
`default_nettype none
// Records that pass the configured filter (type; type and location; type,
// location and inclusive time window; or sensor id) add to a count, a sum and
// a sum of squares. The record flagged with tlast closes the set: one result
// follows with the count, the rounded mean and the truncated population
// standard deviation, or with tuser high and zeros when nothing matched. Each
// record is captured, then accumulated with the 24x24 squarer. Closing a
// non-empty set runs the bit-serial multiplier (three products of 41 steps),
// the restoring divider (two quotients of 82 steps) and the square root (32
// steps), each after a load step, then loads the output register. A finished
// result waits in the output register while new records are taken.
// Configuration writes are always accepted.
module filtered_mean_stdev_accumulator #(
  parameter int MAX_RECORDS = 65536,
  parameter int MEAS_WIDTH  = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // type_code[3:0], location_code[7:4], sensor_ident[23:8],
  // sample_time[55:24], measurement[79:56]
  input  wire logic [79:0] s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // match_total[16:0], mean_value[40:17], std_dev[63:41]
  output logic [63:0]      m_axis_tdata_o,
  // empty_set[0]
  output logic             m_axis_tuser_o
);

  fmsa_pkg::cmd_t    cmd;
  fmsa_pkg::status_t status;
  logic [16:0] total;
  logic [23:0] mean;
  logic [22:0] stdv;

  assign cfg_ready_o = 1'b1;

  fmsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fmsa_dp #(
    .MaxRecords (MAX_RECORDS),
    .MeasWidth  (MEAS_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .type_code_i     (s_axis_tdata_i[3:0]),
    .location_code_i (s_axis_tdata_i[7:4]),
    .sensor_ident_i  (s_axis_tdata_i[23:8]),
    .sample_time_i   (s_axis_tdata_i[55:24]),
    .measurement_i   (s_axis_tdata_i[79:56]),
    .last_item_i     (s_axis_tlast_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .match_total_o   (total),
    .mean_value_o    (mean),
    .std_dev_o       (stdv),
    .empty_set_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {stdv, mean, total};

  // An empty set reports zero count, mean and deviation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("empty result with nonzero payload");

  // A non-empty result always carries a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[16:0] != '0))
    else $error("nonempty result with zero count");

  // After a record that does not close the set, ready drops for the accumulate state and then returns.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i)
      |=> !s_axis_tready_o ##1 s_axis_tready_o)
    else $error("record accumulation did not return to idle");

endmodule
`default_nettype wire

// ----- tb/sv/filtered_mean_stdev_accumulator_tb.sv -----
// Self-checking testbench for the filtered mean and deviation accumulator.
`timescale 1ns / 1ps
module filtered_mean_stdev_accumulator_tb;

  typedef struct {
    logic [3:0]         tc;
    logic [3:0]         lc;
    logic [15:0]        id;
    logic [31:0]        stamp;
    logic signed [23:0] meas;
    logic               last;
  } record_t;

  typedef struct {
    logic [16:0] total;
    logic [23:0] mean;
    logic [22:0] sdev;
    logic        empty;
  } stats_t;

  localparam int HoldCycles = 3000;
  localparam int StallLimit = 20000;
  localparam int MaxCount   = 65536;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // Predictor copy of the registers and accumulators.
  logic [1:0]         p_mode;
  logic [3:0]         p_type;
  logic [3:0]         p_loc;
  logic [15:0]        p_id;
  logic [31:0]        p_wstart;
  logic [31:0]        p_wend;
  logic [16:0]        p_count;
  logic signed [40:0] p_sum;
  logic [63:0]        p_sqsum;

  stats_t pending_stats[$];
  int     errors;
  int     src_idle_pct;
  int     snk_stall_pct;
  int     hold_left;
  int     quiet_cycles;

  filtered_mean_stdev_accumulator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Floor of the square root of a 64-bit value.
  function automatic logic [31:0] root_floor(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if ({32'd0, t} * {32'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  // Statistics of the data set that closes now.
  function automatic stats_t close_set();
    stats_t             s;
    logic [63:0]        n;
    logic [63:0]        mag;
    logic [63:0]        qm;
    logic [127:0]       d;
    logic [127:0]       q;
    logic [63:0]        vr;
    logic [31:0]        sd;
    logic signed [63:0] sum64;
    s = '{default: '0};
    if (p_count == 0) begin
      s.empty = 1'b1;
      return s;
    end
    n = {47'd0, p_count};
    sum64 = p_sum;
    mag = (sum64 < 0) ? 64'(-sum64) : 64'(sum64);
    qm = (2 * mag + n) / (2 * n);
    s.total = p_count;
    s.mean = (sum64 < 0) ? 24'(-qm) : 24'(qm);
    d = {64'd0, n} * {64'd0, p_sqsum} - {64'd0, mag} * {64'd0, mag};
    q = d / ({64'd0, n} * {64'd0, n});
    vr = (q[127:64] != 0) ? '1 : q[63:0];
    sd = root_floor(vr);
    s.sdev = (sd > {9'd0, fmsa_pkg::StdMax}) ? fmsa_pkg::StdMax : sd[22:0];
    return s;
  endfunction

  // Filter decision for one record under the current registers.
  function automatic logic passes_filter(input record_t r);
    case (p_mode)
      fmsa_pkg::MODE_TYPE:     return r.tc == p_type;
      fmsa_pkg::MODE_TYPE_LOC: return r.tc == p_type && r.lc == p_loc;
      fmsa_pkg::MODE_WINDOW:   return r.tc == p_type && r.lc == p_loc &&
                                      r.stamp >= p_wstart && r.stamp <= p_wend;
      default:                 return r.id == p_id;
    endcase
  endfunction

  // Update the accumulators for an accepted record.
  task automatic absorb_record(input record_t r);
    logic signed [47:0] sq;
    sq = r.meas * r.meas;
    if (passes_filter(r) && p_count < MaxCount) begin
      p_count = p_count + 17'd1;
      p_sum = p_sum + 41'(r.meas);
      p_sqsum = p_sqsum + 64'(sq);
    end
    if (r.last) begin
      pending_stats.push_back(close_set());
      p_count = '0;
      p_sum = '0;
      p_sqsum = '0;
    end
  endtask

  // Send one record request; returns just after the accepting edge.
  task automatic send_record(input record_t r);
    logic took;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {r.meas, r.stamp, r.id, r.lc, r.tc};
    s_axis_tlast_i <= r.last;
    do begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
    end while (!took);
    absorb_record(r);
  endtask

  // Let the block drain before touching the registers.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write one configuration register; the channel then idles before the task returns.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    case (idx)
      fmsa_pkg::CFG_FILTER_MODE: p_mode = val[1:0];
      fmsa_pkg::CFG_TYPE_MATCH:  p_type = val[3:0];
      fmsa_pkg::CFG_LOC_MATCH:   p_loc = val[3:0];
      fmsa_pkg::CFG_ID_MATCH:    p_id = val[15:0];
      fmsa_pkg::CFG_WIN_START:   p_wstart = val;
      fmsa_pkg::CFG_WIN_END:     p_wend = val;
      default:                   ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic record_t make_record(input logic [3:0] tc, input logic [3:0] lc,
                                          input logic [15:0] id, input logic [31:0] st,
                                          input logic [23:0] m, input logic last);
    record_t r;
    r.tc = tc;
    r.lc = lc;
    r.id = id;
    r.stamp = st;
    r.meas = m;
    r.last = last;
    return r;
  endfunction

  // Random record, biased toward passing the current filter.
  function automatic record_t random_record(input logic last);
    record_t     r;
    longint      span;
    r.tc = 4'($urandom);
    r.lc = 4'($urandom);
    r.id = 16'($urandom);
    r.stamp = $urandom;
    r.meas = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8191) - 4096);
    r.last = last;
    if ($urandom_range(0, 99) < 75) begin
      r.tc = p_type;
      r.lc = p_loc;
      r.id = p_id;
      if (p_wstart <= p_wend) begin
        span = longint'(p_wend) - longint'(p_wstart) + 1;
        r.stamp = 32'(longint'(p_wstart) + (longint'({$urandom, $urandom}) & 64'h7FFFFFFFFFFF)
                      % span);
      end
    end
    return r;
  endfunction

  // Random register setting, extremes included now and then.
  task automatic random_config();
    logic [31:0] ws;
    logic [31:0] we;
    ws = $urandom;
    we = ws + $urandom_range(0, 1000);
    case ($urandom_range(0, 4))
      0: begin ws = '0; we = '1; end
      1: begin we = ws - 1; end
      2: begin we = ws; end
      default: ;
    endcase
    write_reg(fmsa_pkg::CFG_FILTER_MODE, $urandom);
    write_reg(fmsa_pkg::CFG_TYPE_MATCH, $urandom);
    write_reg(fmsa_pkg::CFG_LOC_MATCH, $urandom);
    write_reg(fmsa_pkg::CFG_ID_MATCH, $urandom);
    write_reg(fmsa_pkg::CFG_WIN_START, ws);
    write_reg(fmsa_pkg::CFG_WIN_END, we);
  endtask

  // Sink ready, with an optional long hold-off.
  always @(posedge clk_i) begin
    m_axis_tready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Hold-off counter.
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Compare each result request with the oldest expectation.
  always @(negedge clk_i) begin
    stats_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_stats.size() == 0) begin
        $error("unexpected result tdata=%h tuser=%b", m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        e = pending_stats.pop_front();
        if (m_axis_tdata_o[16:0] !== e.total) begin
          $error("match_total expected %0d actual %0d", e.total, m_axis_tdata_o[16:0]);
          errors++;
        end
        if (m_axis_tdata_o[40:17] !== e.mean) begin
          $error("mean_value expected %h actual %h", e.mean, m_axis_tdata_o[40:17]);
          errors++;
        end
        if (m_axis_tdata_o[63:41] !== e.sdev) begin
          $error("std_dev expected %h actual %h", e.sdev, m_axis_tdata_o[63:41]);
          errors++;
        end
        if (m_axis_tuser_o !== e.empty) begin
          $error("empty_set expected %b actual %b", e.empty, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("filtered_mean_stdev_accumulator_tb: FAIL");
      $finish;
    end
  end

  // Reset defaults, empty sets and register masking.
  task automatic test_defaults();
    send_record(make_record(4'd0, 4'd3, 16'h1234, 32'd0, 24'sd256, 1'b0));
    send_record(make_record(4'd5, 4'd3, 16'h1234, 32'd0, 24'sd999, 1'b0));
    send_record(make_record(4'd0, 4'd9, 16'hFFFF, '1, -24'sd512, 1'b1));
    send_record(make_record(4'd7, 4'd0, 16'h0000, 32'd5, 24'sd1, 1'b1));
    wait_idle();
    write_reg(fmsa_pkg::CFG_FILTER_MODE, 32'hFFFF_FFFC);
    write_reg(fmsa_pkg::CFG_TYPE_MATCH, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0000_0003);
    send_record(make_record(4'hF, 4'hF, 16'h0000, 32'd0, 24'sh7FFFFF, 1'b0));
    send_record(make_record(4'hF, 4'hF, 16'h0000, 32'd0, 24'sh800000, 1'b1));
    wait_idle();
  endtask

  // Type-and-location, window and ident filter modes, inclusive window bounds and a reversed window.
  task automatic test_modes();
    write_reg(fmsa_pkg::CFG_FILTER_MODE, 32'(fmsa_pkg::MODE_TYPE_LOC));
    write_reg(fmsa_pkg::CFG_TYPE_MATCH, 32'd2);
    write_reg(fmsa_pkg::CFG_LOC_MATCH, 32'hFFFF_FFF7);
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd9, 24'sd100, 1'b0));
    send_record(make_record(4'd2, 4'd6, 16'd1, 32'd9, 24'sd300, 1'b0));
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd9, 24'sd101, 1'b1));
    wait_idle();
    write_reg(fmsa_pkg::CFG_FILTER_MODE, 32'(fmsa_pkg::MODE_WINDOW));
    write_reg(fmsa_pkg::CFG_WIN_START, 32'd1000);
    write_reg(fmsa_pkg::CFG_WIN_END, 32'd2000);
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd999, 24'sd50, 1'b0));
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd1000, 24'sd60, 1'b0));
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd2000, -24'sd70, 1'b0));
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd2001, 24'sd80, 1'b1));
    wait_idle();
    // Start above end: nothing can match.
    write_reg(fmsa_pkg::CFG_WIN_START, 32'd3000);
    send_record(make_record(4'd2, 4'd7, 16'd1, 32'd2500, 24'sd1, 1'b1));
    wait_idle();
    write_reg(fmsa_pkg::CFG_FILTER_MODE, 32'(fmsa_pkg::MODE_IDENT));
    write_reg(fmsa_pkg::CFG_ID_MATCH, 32'hABCD_FFFF);
    send_record(make_record(4'd0, 4'd0, 16'hFFFF, 32'd0, -24'sd3, 1'b0));
    send_record(make_record(4'd1, 4'd1, 16'hFFFE, 32'd0, 24'sd9, 1'b0));
    send_record(make_record(4'd9, 4'd2, 16'hFFFF, '1, -24'sd4, 1'b1));
    wait_idle();
  endtask

  // Largest deviation: the two extreme measurements in one set.
  task automatic test_limits();
    send_record(make_record(4'd0, 4'd0, 16'hFFFF, 32'd0, 24'sh800000, 1'b0));
    send_record(make_record(4'd0, 4'd0, 16'hFFFF, 32'd0, 24'sh7FFFFF, 1'b1));
    wait_idle();
  endtask

  // Random data sets under one idling setting.
  task automatic test_random(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    int len;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      random_config();
      for (int s = 0; s < 4; s++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_record(random_record(i == len - 1));
        sent += len;
      end
      wait_idle();
    end
  endtask

  // Long sink hold-off while the sender keeps offering records.
  task automatic test_backpressure();
    int len;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left <= HoldCycles;
    for (int s = 0; s < 6; s++) begin
      len = $urandom_range(2, 6);
      for (int i = 0; i < len; i++) send_record(random_record(i == len - 1));
    end
    wait_idle();
  endtask

  initial begin
    errors = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    m_axis_tready_i = 1'b0;
    p_mode = fmsa_pkg::MODE_TYPE;
    p_type = '0;
    p_loc = '0;
    p_id = '0;
    p_wstart = '0;
    p_wend = '1;
    p_count = '0;
    p_sum = '0;
    p_sqsum = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_modes();
    test_limits();
    test_random(0, 0, 150);
    test_random(61, 0, 150);
    test_random(0, 61, 150);
    test_random(20, 20, 150);
    test_backpressure();
    repeat (600) @(posedge clk_i);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("filtered_mean_stdev_accumulator_tb: PASS");
    end else begin
      $display("filtered_mean_stdev_accumulator_tb: FAIL");
    end
    $finish;
  end

endmodule
